// File: src/slope_color_ramp_assert.svh
// assertion macros for the slope color ramp
// include this file inside any module that checks its own pipeline
`ifndef SLOPE_COLOR_RAMP_ASSERT_SVH
`define SLOPE_COLOR_RAMP_ASSERT_SVH
`ifndef SYNTHESIS
`define SCR_ASSERT_IMPLIES(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("slope_color_ramp check failed");
`define SCR_ASSERT_NEXT(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("slope_color_ramp check failed");
`else
`define SCR_ASSERT_IMPLIES(name, clk_s, rst_s, ante, cons)
`define SCR_ASSERT_NEXT(name, clk_s, rst_s, ante, cons)
`endif
`endif

// File: src/scr_pkg.sv
// shared constants and types for the slope color ramp
// no dependencies
`default_nettype none
package scr_pkg;
  localparam int SLOPE_WIDTH_DEFAULT = 16;
  localparam int COLOR_WIDTH = 24;
  localparam int CHAN_WIDTH = 8;
  localparam int NUM_CHAN = 3;
  localparam int QUOT_BITS = 8;
  localparam int CFG_INDEX_WIDTH = 3;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_LOW_STOP   = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MID_STOP   = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_HIGH_STOP  = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_LOW_COLOR  = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MID_COLOR  = 3'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_HIGH_COLOR = 3'd5;

  typedef logic [CHAN_WIDTH-1:0] chan_t;
  typedef logic [COLOR_WIDTH-1:0] color_t;

  localparam color_t LOW_COLOR_RESET  = 24'h000000;
  localparam color_t MID_COLOR_RESET  = 24'h7A7A7A;
  localparam color_t HIGH_COLOR_RESET = 24'hFFFFFF;
endpackage
`default_nettype wire

// File: src/scr_div_pipe.sv
// pipelined restoring divider, one quotient bit per stage, three lanes
// sharing one divisor; depends on scr_pkg
`default_nettype none
module scr_div_pipe #(
  parameter int NUM_WIDTH = 26,
  parameter int DEN_WIDTH = 17
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic [NUM_WIDTH-1:0] num [scr_pkg::NUM_CHAN],
  input  wire logic [DEN_WIDTH-1:0] den,
  output logic                     out_valid,
  output scr_pkg::chan_t           quot [scr_pkg::NUM_CHAN]
);
  import scr_pkg::*;

  // the last stage only produces a quotient bit, so divisor and remainder
  // are carried through the first QUOT_BITS-1 stages only
  logic                 vld   [0:QUOT_BITS];
  logic [DEN_WIDTH-1:0] den_p [0:QUOT_BITS-1];
  logic [NUM_WIDTH-1:0] rem   [0:QUOT_BITS-1][NUM_CHAN];
  chan_t                q     [0:QUOT_BITS][NUM_CHAN];

  assign vld[0]   = in_valid;
  assign den_p[0] = den;

  for (genvar k = 0; k < NUM_CHAN; k++) begin : g_in
    assign rem[0][k] = num[k];
    assign q[0][k]   = '0;
    assign quot[k]   = q[QUOT_BITS][k];
  end

  for (genvar j = 0; j < QUOT_BITS; j++) begin : g_stage
    localparam int BIT = QUOT_BITS - 1 - j;
    logic [NUM_WIDTH-1:0] shifted;
    assign shifted = NUM_WIDTH'(den_p[j]) << BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else begin
        vld[j+1] <= vld[j];
      end
    end

    if (j < QUOT_BITS - 1) begin : g_den
      always_ff @(posedge clk) begin
        den_p[j+1] <= den_p[j];
      end
    end

    for (genvar k = 0; k < NUM_CHAN; k++) begin : g_lane
      logic ge;
      assign ge = rem[j][k] >= shifted;
      always_ff @(posedge clk) begin
        q[j+1][k] <= {q[j][k][CHAN_WIDTH-2:0], ge};
      end
      if (j < QUOT_BITS - 1) begin : g_rem
        always_ff @(posedge clk) begin
          rem[j+1][k] <= ge ? rem[j][k] - shifted : rem[j][k];
        end
      end
    end
  end

  assign out_valid = vld[QUOT_BITS];
endmodule
`default_nettype wire

// File: src/slope_color_ramp.sv
// slope color ramp: an accepted request passes through these stages to done
// (select stage, multiply stage, numerator stage, 8 divider stages)
// throughput one request per cycle; the 8-stage restoring divider sets the depth
// results are never held off, so busy is only high during reset
// synchronous reset clears all stage valid bits and restores the stop and color registers
`default_nettype none
`include "slope_color_ramp_assert.svh"
module slope_color_ramp #(
  parameter int SLOPE_WIDTH = scr_pkg::SLOPE_WIDTH_DEFAULT
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic [SLOPE_WIDTH-1:0]                slope,
  output logic                                       done,
  output logic [scr_pkg::CHAN_WIDTH-1:0]             red,
  output logic [scr_pkg::CHAN_WIDTH-1:0]             green,
  output logic [scr_pkg::CHAN_WIDTH-1:0]             blue,
  input  wire logic                                  cfg_wr,
  input  wire logic [scr_pkg::CFG_INDEX_WIDTH-1:0]   cfg_addr,
  input  wire logic [(SLOPE_WIDTH > scr_pkg::COLOR_WIDTH ?
                      SLOPE_WIDTH : scr_pkg::COLOR_WIDTH)-1:0] cfg_data
);
  import scr_pkg::*;

  // numerator 2*(c0*rest + c1*off) + span stays below 512*span
  localparam int PROD_WIDTH = SLOPE_WIDTH + CHAN_WIDTH;
  localparam int NUM_WIDTH  = SLOPE_WIDTH + CHAN_WIDTH + 2;
  localparam int DEN_WIDTH  = SLOPE_WIDTH + 1;
  localparam int LATENCY    = 3 + QUOT_BITS;

  // configuration registers
  logic [SLOPE_WIDTH-1:0] low_stop, mid_stop, high_stop;
  color_t                 low_color, mid_color, high_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_stop   <= '0;
      mid_stop   <= '0;
      high_stop  <= '0;
      low_color  <= LOW_COLOR_RESET;
      mid_color  <= MID_COLOR_RESET;
      high_color <= HIGH_COLOR_RESET;
    end else if (cfg_wr) begin
      case (cfg_addr)
        REG_LOW_STOP:   low_stop   <= cfg_data[SLOPE_WIDTH-1:0];
        REG_MID_STOP:   mid_stop   <= cfg_data[SLOPE_WIDTH-1:0];
        REG_HIGH_STOP:  high_stop  <= cfg_data[SLOPE_WIDTH-1:0];
        REG_LOW_COLOR:  low_color  <= cfg_data[COLOR_WIDTH-1:0];
        REG_MID_COLOR:  mid_color  <= cfg_data[COLOR_WIDTH-1:0];
        REG_HIGH_COLOR: high_color <= cfg_data[COLOR_WIDTH-1:0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  assign busy = rst;

  logic accept;
  assign accept = start && !busy;

  // stage 1: pick the segment and form offset, remainder of span, span
  // clamped slopes and empty segments become off 0, span 1, which
  // makes the divider return the start color unchanged
  logic [SLOPE_WIDTH-1:0] seg_a, seg_b;
  color_t                 sel_c0, sel_c1;
  logic                   clamp;
  logic [SLOPE_WIDTH-1:0] off_next, rest_next, span_next;

  always_comb begin
    seg_a  = mid_stop;
    seg_b  = high_stop;
    sel_c0 = mid_color;
    sel_c1 = high_color;
    clamp  = 1'b0;
    if (slope < low_stop) begin
      sel_c0 = low_color;
      sel_c1 = low_color;
      clamp  = 1'b1;
    end else if (slope > high_stop) begin
      sel_c0 = high_color;
      sel_c1 = high_color;
      clamp  = 1'b1;
    end else if (slope < mid_stop) begin
      seg_a  = low_stop;
      seg_b  = mid_stop;
      sel_c0 = low_color;
      sel_c1 = mid_color;
    end
    if (clamp || seg_b <= seg_a) begin
      off_next  = '0;
      rest_next = SLOPE_WIDTH'(1);
      span_next = SLOPE_WIDTH'(1);
    end else begin
      off_next  = slope - seg_a;
      rest_next = seg_b - slope;
      span_next = seg_b - seg_a;
    end
  end

  logic                   v1;
  logic [SLOPE_WIDTH-1:0] off1, rest1, span1;
  color_t                 c0_1, c1_1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    off1  <= off_next;
    rest1 <= rest_next;
    span1 <= span_next;
    c0_1  <= sel_c0;
    c1_1  <= sel_c1;
  end

  // stage 2: weight each end color, one pair of products per channel
  logic                   v2;
  logic [SLOPE_WIDTH-1:0] span2;
  logic [PROD_WIDTH-1:0]  p0 [NUM_CHAN];
  logic [PROD_WIDTH-1:0]  p1 [NUM_CHAN];

  // stage 3: rounding numerator, halves added as one span
  logic                   v3;
  logic [SLOPE_WIDTH-1:0] span3;
  logic [NUM_WIDTH-1:0]   num3 [NUM_CHAN];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    span2 <= span1;
    span3 <= span2;
  end

  for (genvar k = 0; k < NUM_CHAN; k++) begin : g_chan
    logic [PROD_WIDTH:0] wsum;
    assign wsum = {1'b0, p0[k]} + {1'b0, p1[k]};
    always_ff @(posedge clk) begin
      p0[k]   <= PROD_WIDTH'(c0_1[CHAN_WIDTH*k +: CHAN_WIDTH]) * PROD_WIDTH'(rest1);
      p1[k]   <= PROD_WIDTH'(c1_1[CHAN_WIDTH*k +: CHAN_WIDTH]) * PROD_WIDTH'(off1);
      num3[k] <= NUM_WIDTH'({wsum, 1'b0}) + NUM_WIDTH'(span2);
    end
  end

  // stages 4 to 11: divide by twice the span, quotient is the channel
  chan_t quot [NUM_CHAN];

  scr_div_pipe #(
    .NUM_WIDTH (NUM_WIDTH),
    .DEN_WIDTH (DEN_WIDTH)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v3),
    .num       (num3),
    .den       ({span3, 1'b0}),
    .out_valid (done),
    .quot      (quot)
  );

  assign red   = quot[0];
  assign green = quot[1];
  assign blue  = quot[2];

  // every request enters the pipeline on the next cycle
  `SCR_ASSERT_NEXT(a_enter, clk, rst, accept, v1)
  // a result only ever comes from a request taken the fixed latency earlier
  `SCR_ASSERT_IMPLIES(a_latency, clk, rst, done, $past(accept, LATENCY))
  // segment math never divides by zero and the offset stays inside the span
  `SCR_ASSERT_IMPLIES(a_span, clk, rst, v1, (span1 != '0) && (off1 <= span1))
  // numerators keep the quotient within one channel
  `SCR_ASSERT_IMPLIES(a_num_range, clk, rst, v3, (num3[0] < (NUM_WIDTH'(span3) << 9)) && (num3[1] < (NUM_WIDTH'(span3) << 9)) && (num3[2] < (NUM_WIDTH'(span3) << 9)))
endmodule
`default_nettype wire

// File: tb/tb_slope_color_ramp.sv
// self-checking testbench for slope_color_ramp: random and directed slope requests
// against an in-bench predictor of the three stop color ramp; depends on scr_pkg
`timescale 1ns / 1ps
module tb_slope_color_ramp;
  import scr_pkg::*;

  // register indexes with no register behind them, writes there are dropped
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNMAPPED_A = 3'd6;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNMAPPED_B = 3'd7;
  localparam int SW = SLOPE_WIDTH_DEFAULT;
  localparam int LATENCY_PAD = 15;  // a little over the 11 pipeline stages
  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 100;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [SW-1:0] slope = '0;
  logic cfg_wr = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_addr = '0;
  logic [COLOR_WIDTH-1:0] cfg_data = '0;
  logic busy;
  logic done;
  chan_t red;
  chan_t green;
  chan_t blue;

  slope_color_ramp uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .slope(slope),
    .done(done),
    .red(red),
    .green(green),
    .blue(blue),
    .cfg_wr(cfg_wr),
    .cfg_addr(cfg_addr),
    .cfg_data(cfg_data)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // bench copy of the ramp registers, kept in step with every write
  logic [SW-1:0] stop_low = '0;
  logic [SW-1:0] stop_mid = '0;
  logic [SW-1:0] stop_high = '0;
  color_t color_low = LOW_COLOR_RESET;
  color_t color_mid = MID_COLOR_RESET;
  color_t color_high = HIGH_COLOR_RESET;

  logic [SW-1:0] pending_slopes[$];   // requests not yet offered to the block
  color_t expected_colors[$];         // colors owed by accepted requests, oldest first
  color_t want_color;
  int sender_idle_pct = 0;
  int mismatch_count = 0;
  int requests_accepted = 0;
  int colors_checked = 0;
  int ramp_settings = 1;
  int reg_writes = 0;

  // one channel of the blend, exact and rounded half up:
  // floor((2*span*c0 + 2*off*(c1-c0) + span) / (2*span))
  function automatic chan_t blend_channel(longint c0, longint c1, longint off, longint span);
    longint num;
    num = 2 * span * c0 + 2 * off * (c1 - c0) + span;
    return chan_t'(num / (2 * span));
  endfunction

  // color the block should give for one slope under the current registers
  function automatic color_t ramp_color(logic [SW-1:0] s);
    longint seg_start;
    longint seg_end;
    color_t c0;
    color_t c1;
    color_t mixed;
    // outside the stops the end colors are clamped
    if (s < stop_low) return color_low;
    if (s > stop_high) return color_high;
    // pick the segment; [low, mid) is the first, everything else the second
    if (s < stop_mid) begin
      seg_start = stop_low;
      seg_end = stop_mid;
      c0 = color_low;
      c1 = color_mid;
    end else begin
      seg_start = stop_mid;
      seg_end = stop_high;
      c0 = color_mid;
      c1 = color_high;
    end
    // a segment with no positive span just gives its start color
    if (seg_end <= seg_start) return c0;
    for (int k = 0; k < NUM_CHAN; k++) begin
      mixed[CHAN_WIDTH*k +: CHAN_WIDTH] = blend_channel(c0[CHAN_WIDTH*k +: CHAN_WIDTH],
          c1[CHAN_WIDTH*k +: CHAN_WIDTH], longint'(s) - seg_start, seg_end - seg_start);
    end
    return mixed;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("mismatch at %0t ns: %s got %0h want %0h", $time, what, got, want);
  endtask

  // request driver: holds start until the request is taken, idles at random
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        // request accepted at this edge, registers are stable while requests flow
        expected_colors.push_back(ramp_color(slope));
        requests_accepted++;
      end
      if (!start || !busy) begin
        if (pending_slopes.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          start <= 1'b1;
          slope <= pending_slopes.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // result monitor: every done pulse must match the oldest owed color
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_colors.size() == 0) begin
        report_mismatch("result with no request", {blue, green, red}, 0);
      end else begin
        want_color = expected_colors.pop_front();
        colors_checked++;
        if (red !== want_color[7:0])
          report_mismatch("red", red, want_color[7:0]);
        if (green !== want_color[15:8])
          report_mismatch("green", green, want_color[15:8]);
        if (blue !== want_color[23:16])
          report_mismatch("blue", blue, want_color[23:16]);
      end
    end
  end

  // one register write on the config port, mirrored into the bench copy
  task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [COLOR_WIDTH-1:0] value);
    @(posedge clk);
    cfg_wr <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= value;
    reg_writes++;
    case (idx)
      REG_LOW_STOP: stop_low = value[SW-1:0];
      REG_MID_STOP: stop_mid = value[SW-1:0];
      REG_HIGH_STOP: stop_high = value[SW-1:0];
      REG_LOW_COLOR: color_low = value;
      REG_MID_COLOR: color_mid = value;
      REG_HIGH_COLOR: color_high = value;
      default: ;  // unmapped index, block ignores it
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_wr <= 1'b0;
    ramp_settings++;
  endtask

  // wait until every queued request was taken and answered, then let the pipe settle
  task automatic wait_drained();
    @(negedge clk);
    while (pending_slopes.size() != 0 || start || expected_colors.size() != 0)
      @(negedge clk);
    repeat (LATENCY_PAD) @(posedge clk);
  endtask

  // stop code with the ends of the range favored
  function automatic logic [SW-1:0] pick_stop();
    case ($urandom_range(4))
      0: return '0;
      1: return '1;
      default: return SW'($urandom);
    endcase
  endfunction

  function automatic color_t pick_color();
    case ($urandom_range(4))
      0: return '0;
      1: return '1;
      default: return color_t'($urandom);
    endcase
  endfunction

  // new random ramp: mostly ordered stops, sometimes unordered or collapsed
  task automatic load_random_ramp();
    logic [SW-1:0] a;
    logic [SW-1:0] b;
    logic [SW-1:0] c;
    logic [SW-1:0] t;
    a = pick_stop();
    b = pick_stop();
    c = pick_stop();
    if ($urandom_range(9) < 7) begin
      // sort so that a <= b <= c
      if (a > b) begin t = a; a = b; b = t; end
      if (b > c) begin t = b; b = c; c = t; end
      if (a > b) begin t = a; a = b; b = t; end
    end
    if ($urandom_range(9) == 0) b = a;    // collapsed first segment
    if ($urandom_range(9) == 0) c = b;    // collapsed second segment
    // upper data bits are junk on stop writes, the block keeps only the low bits
    write_reg(REG_LOW_STOP, {8'($urandom), a});
    write_reg(REG_MID_STOP, {8'($urandom), b});
    write_reg(REG_HIGH_STOP, {8'($urandom), c});
    write_reg(REG_LOW_COLOR, pick_color());
    write_reg(REG_MID_COLOR, pick_color());
    write_reg(REG_HIGH_COLOR, pick_color());
    if ($urandom_range(3) == 0)
      write_reg($urandom_range(1) ? REG_UNMAPPED_A : REG_UNMAPPED_B, color_t'($urandom));
    end_writes();
  endtask

  // slope mix: uniform codes, codes around each stop, range ends, codes between stops
  function automatic logic [SW-1:0] pick_slope();
    logic [SW-1:0] near;
    case ($urandom_range(9))
      0, 1, 2, 3: return SW'($urandom);
      4: near = stop_low;
      5: near = stop_mid;
      6: near = stop_high;
      7: return $urandom_range(1) ? '1 : '0;
      default: return SW'($urandom_range(stop_high, stop_low));
    endcase
    return near + SW'($urandom_range(6)) - SW'(3);
  endfunction

  // main sequence
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    sender_idle_pct = 34;

    // reset registers: all stops at zero, so zero maps to the mid color and
    // anything above it clamps to the high color
    pending_slopes = {16'd0, 16'd1, 16'hFFFF};
    wait_drained();

    // ordered stops, channels rising and falling across both segments
    write_reg(REG_LOW_STOP, 24'd1000);
    write_reg(REG_MID_STOP, 24'd30000);
    write_reg(REG_HIGH_STOP, 24'd60000);
    write_reg(REG_LOW_COLOR, 24'h00FF80);
    write_reg(REG_MID_COLOR, 24'hFF0040);
    write_reg(REG_HIGH_COLOR, 24'h10FFFF);
    end_writes();
    pending_slopes = {16'd0, 16'd999, 16'd1000, 16'd1001, 16'd15500, 16'd29999,
                      16'd30000, 16'd45000, 16'd60000, 16'd60001, 16'hFFFF};
    wait_drained();

    // all stops equal: zero span segment, stop writes carry junk upper bits,
    // writes to unmapped indexes must leave the registers alone
    write_reg(REG_LOW_STOP, 24'hAB1388);
    write_reg(REG_MID_STOP, 24'h551388);
    write_reg(REG_HIGH_STOP, 24'hFF1388);
    write_reg(REG_UNMAPPED_A, 24'hFFFFFF);
    write_reg(REG_UNMAPPED_B, 24'h000000);
    end_writes();
    pending_slopes = {16'd4999, 16'd5000, 16'd5001};
    wait_drained();

    // unordered stops: mid above high, the comparisons apply as they stand
    write_reg(REG_LOW_STOP, 24'd100);
    write_reg(REG_MID_STOP, 24'd50000);
    write_reg(REG_HIGH_STOP, 24'd20000);
    end_writes();
    pending_slopes = {16'd99, 16'd100, 16'd20000, 16'd20001, 16'hFFFF};
    wait_drained();

    // random phases: sender idles a third, then two thirds, then never
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      sender_idle_pct = (p < 3) ? 34 : (p < 6) ? 68 : 0;
      if (p == 0) begin
        // widest span with full swing colors, hardest rounding
        write_reg(REG_LOW_STOP, 24'h000000);
        write_reg(REG_MID_STOP, 24'h008000);
        write_reg(REG_HIGH_STOP, 24'h00FFFF);
        write_reg(REG_LOW_COLOR, 24'h000000);
        write_reg(REG_MID_COLOR, 24'hFFFFFF);
        write_reg(REG_HIGH_COLOR, 24'h000000);
        end_writes();
      end else begin
        load_random_ramp();
      end
      repeat (ITEMS_PER_PHASE) pending_slopes.push_back(pick_slope());
      wait_drained();
    end

    // anything still owed at this point never came out
    if (expected_colors.size() != 0)
      report_mismatch("results missing at end", 0, expected_colors.size());

    $display("run covered %0d slope requests under %0d ramp settings (%0d register writes)",
             requests_accepted, ramp_settings, reg_writes);
    $display("%0d colors checked, %0d mismatches", colors_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("timeout with %0d results still owed", expected_colors.size());
    $display("FAILED: results differ");
    $finish;
  end
endmodule
